@@ design/ssh_pkg.sv @@
// ---------------------------------------------------------------------------
// ssh_pkg
// shared types and constants of the sha-256 stream hasher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssh_pkg;

  typedef logic [7:0][31:0] hash_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam hash_t INIT_VEC = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

@@ design/ssh_round.sv @@
// ---------------------------------------------------------------------------
// ssh_round
// one sha-256 compression round on the working variables
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssh_round (
  input  ssh_pkg::hash_t v,
  input  logic [31:0]    k,
  input  logic [31:0]    w,
  output ssh_pkg::hash_t v_next
);
  import ssh_pkg::*;

  logic [31:0] sig1, ch, sig0, maj, t1, t2;

  // round functions, v[0] is a
  always_comb begin
    sig1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    sig0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1   = v[7] + sig1 + ch + k + w;
    t2   = sig0 + maj;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

endmodule

`default_nettype wire

@@ design/sha256_stream_hasher.sv @@
// ---------------------------------------------------------------------------
// sha256_stream_hasher
// sha-256 over big-endian words with padding and digest output
// ---------------------------------------------------------------------------
// channel  handshake            payload
// in       in_valid / in_stall  msg_word, valid_bytes, last_word
// out      out_valid/ out_stall digest_word, digest_index, digest_last
//
// an item that does not close a block frees the input for the next; the
// sixteenth word starts a compression (16 rounds on stored words, 48 that
// first expand one through the two read ports of the schedule memory) and the
// chain add. a last item adds padding words, one a cycle outside compressions,
// one or two compressions, then eight digest items, each held until taken.
// reset is synchronous; no clearing pass. out_stall only holds the digest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] msg_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_last
);
  import ssh_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD   = 8'b0000_0010,
    S_RD_A  = 8'b0000_0100,
    S_RD_B  = 8'b0000_1000,
    S_WCALC = 8'b0001_0000,
    S_ROUND = 8'b0010_0000,
    S_FINAL = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    PAD_80   = 3'b001,
    PAD_FILL = 3'b010,
    PAD_LO   = 3'b100
  } pad_t;

  state_t      state;
  pad_t        pad_step;
  logic        pad_active, finish;
  logic [3:0]  pos;
  logic [63:0] bit_len;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  hash_t       chain, v, v_next;
  logic [31:0] w_reg, x2, x7, w_new, w_round;

  // schedule memory, one write port and two registered read ports
  logic [31:0] sched [16];
  logic        we;
  logic [3:0]  wa, ra0, ra1;
  logic [31:0] wd, rd0, rd1;

  always_ff @(posedge clk) begin
    if (we) begin
      sched[wa] <= wd;
    end
    rd0 <= sched[ra0];
    rd1 <= sched[ra1];
  end

  logic        in_acc, out_acc;
  logic [2:0]  cnt;
  logic [31:0] keep, mark, push_word;
  logic        push_en;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign digest_word  = chain[out_idx];
  assign digest_index = out_idx;
  assign digest_last  = (out_idx == 3'd7);

  // effective byte count and masking of the closing word
  always_comb begin
    cnt = (!last_word || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    case (cnt)
      3'd0:    begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
      3'd1:    begin keep = 32'hff00_0000; mark = 32'h0080_0000; end
      3'd2:    begin keep = 32'hffff_0000; mark = 32'h0000_8000; end
      3'd3:    begin keep = 32'hffff_ff00; mark = 32'h0000_0080; end
      default: begin keep = 32'hffff_ffff; mark = 32'h0000_0000; end
    endcase
  end

  // word pushed into the block this cycle
  always_comb begin
    push_en   = 1'b0;
    push_word = 32'h0;
    if (state == S_IDLE && in_acc) begin
      push_en   = 1'b1;
      push_word = (msg_word & keep) | mark;
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      unique case (pad_step)
        PAD_80:   push_word = PAD_WORD;
        PAD_FILL: push_word = (pos == 4'd14) ? bit_len[63:32] : 32'h0;
        PAD_LO:   push_word = bit_len[31:0];
        default:  push_word = 32'h0;
      endcase
    end
  end

  // message schedule expansion
  always_comb begin
    w_new = (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10)) + x7
          + (rotr(rd0, 7) ^ rotr(rd0, 18) ^ (rd0 >> 3)) + rd1;
    w_round = (round < 6'd16) ? rd0 : w_reg;
  end

  // memory port selection
  always_comb begin
    we  = push_en;
    wa  = pos;
    wd  = push_word;
    ra0 = round[3:0];
    ra1 = round[3:0];
    if (state == S_WCALC) begin
      we = 1'b1;
      wa = round[3:0];
      wd = w_new;
    end
    if (state == S_RD_A && round >= 6'd16) begin
      ra0 = round[3:0] - 4'd2;
      ra1 = round[3:0] - 4'd7;
    end else if (state == S_RD_B) begin
      ra0 = round[3:0] - 4'd15;
      ra1 = round[3:0];
    end
  end

  ssh_round u_round (
    .v      (v),
    .k      (ROUND_K[round]),
    .w      (w_round),
    .v_next (v_next)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pad_step   <= PAD_80;
      pad_active <= 1'b0;
      finish     <= 1'b0;
      pos        <= 4'd0;
      bit_len    <= 64'd0;
      round      <= 6'd0;
      out_idx    <= 3'd0;
      chain      <= INIT_VEC;
    end else begin
      // accepted item
      if (state == S_IDLE && in_acc) begin
        bit_len <= bit_len + 64'({cnt, 3'b000});
        if (last_word) begin
          pad_active <= 1'b1;
          pad_step   <= (cnt == 3'd4) ? PAD_80 : PAD_FILL;
          // a word that closes the block goes to the compression first
          if (pos != 4'd15) begin
            state <= S_PAD;
          end
        end
      end
      // padding step
      if (state == S_PAD) begin
        unique case (pad_step)
          PAD_80:   pad_step <= PAD_FILL;
          PAD_FILL: if (pos == 4'd14) pad_step <= PAD_LO;
          PAD_LO:   finish <= 1'b1;
          default:  pad_step <= PAD_80;
        endcase
      end
      // block position, full block starts compression
      if (push_en) begin
        if (pos == 4'd15) begin
          pos   <= 4'd0;
          v     <= chain;
          round <= 6'd0;
          state <= S_RD_A;
        end else begin
          pos <= pos + 4'd1;
        end
      end
      unique case (state)
        S_RD_A: state <= (round < 6'd16) ? S_ROUND : S_RD_B;
        S_RD_B: begin
          x2    <= rd0;
          x7    <= rd1;
          state <= S_WCALC;
        end
        S_WCALC: begin
          w_reg <= w_new;
          state <= S_ROUND;
        end
        S_ROUND: begin
          v <= v_next;
          if (round == 6'd63) begin
            state <= S_FINAL;
          end else begin
            round <= round + 6'd1;
            state <= S_RD_A;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          round <= 6'd0;
          if (finish) begin
            state   <= S_OUT;
            out_idx <= 3'd0;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              chain      <= INIT_VEC;
              pos        <= 4'd0;
              bit_len    <= 64'd0;
              pad_active <= 1'b0;
              finish     <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while digest pending");
  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 6'd63) |=> state == S_FINAL)
    else $error("compression did not end after round 63");
  a_digest_done: assert property (@(posedge clk) disable iff (rst)
    (out_acc && digest_last) |=> (!out_valid && !in_stall))
    else $error("hasher not idle after last digest item");

endmodule

`default_nettype wire

@@ bench/sha256_stream_hasher_test.sv @@
// ---------------------------------------------------------------------------
// sha256_stream_hasher_test
// self-checking bench: directed messages from a table, then random messages,
// each digest word checked in order against a sha-256 predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_test;
  import ssh_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] msg_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        has_exp;
    logic [31:0] exp_h0;
  } stim_row_t;

  // predictor state
  logic [31:0] chain_q [8];
  logic [31:0] sched_q [16];
  int          slot_q;
  logic [63:0] bits_q;

  digest_item_t digest_fifo [$];
  logic [31:0]  h0_override [$];
  int           h0_pos [$];

  int  errors;
  int  mismatches;
  int  cycle_count;
  bit  quiet_out;
  bit  hold_out;
  int  accepted_cnt;

  sha256_stream_hasher i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .msg_word     (msg_word),
    .valid_bytes  (valid_bytes),
    .last_word    (last_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .digest_index (digest_index),
    .digest_last  (digest_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one compression of the gathered block into the chain
  task automatic sha_compress();
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = sched_q[t];
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += v[i];
  endtask

  task automatic sha_push(logic [31:0] w);
    sched_q[slot_q] = w;
    slot_q++;
    if (slot_q == 16) begin
      sha_compress();
      slot_q = 0;
    end
  endtask

  task automatic sha_reset();
    for (int i = 0; i < 8; i++) chain_q[i] = INIT_VEC[i];
    slot_q = 0;
    bits_q = '0;
  endtask

  // predict the digest items caused by one accepted item
  task automatic sha_accept(logic [31:0] w, logic [2:0] nb, logic lst);
    int cnt;
    logic [31:0] keep;
    cnt = (nb > 4 || !lst) ? 4 : int'(nb);
    bits_q += 64'(cnt * 8);
    if (!lst) begin
      sha_push(w);
      return;
    end
    if (cnt == 4) begin
      sha_push(w);
      sha_push(PAD_WORD);
    end else begin
      keep = (cnt == 0) ? 32'h0 : (32'hffffffff << ((4 - cnt) * 8));
      sha_push((w & keep) | (PAD_WORD >> (cnt * 8)));
    end
    while (slot_q != 14) sha_push(32'h0);
    sha_push(bits_q[63:32]);
    sha_push(bits_q[31:0]);
    for (int k = 0; k < 8; k++)
      digest_fifo.push_back('{chain_q[k], 3'(k), k == 7});
    sha_reset();
  endtask

  // input driver: one item, random gaps, waits for acceptance
  task automatic send_item(logic [31:0] w, logic [2:0] nb, logic lst, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    msg_word    <= w;
    valid_bytes <= nb;
    last_word   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sha_accept(w, nb, lst);
    accepted_cnt++;
    @(negedge clk);
  endtask

  // input goes idle once a run of items is over
  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  // output stall driver
  initial begin
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_out) out_stall <= 1'b1;
      else if (quiet_out) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 20);
    end
  end

  // result checker
  always @(posedge clk) begin
    digest_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (digest_fifo.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest item %h idx %0d", digest_word, digest_index);
      end else begin
        exp_item = digest_fifo.pop_front();
        if (h0_pos.size() != 0 && exp_item.index == 0) begin
          if (h0_override[0] !== exp_item.word) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("known digest h0 %h, predictor %h", h0_override[0], exp_item.word);
          end
          void'(h0_override.pop_front());
          void'(h0_pos.pop_front());
        end
        if (digest_word !== exp_item.word || digest_index !== exp_item.index ||
            digest_last !== exp_item.last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                     exp_item.word, exp_item.index, exp_item.last,
                     digest_word, digest_index, digest_last);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // directed rows; known h0 only for well-known messages
  stim_row_t dir_rows [] = '{
    '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'he3b0c442},  // empty message
    '{32'h61626300, 3'd3, 1'b1, 1'b1, 32'hba7816bf},  // "abc"
    '{32'h616263ff, 3'd3, 1'b1, 1'b1, 32'hba7816bf},  // "abc" with junk tail byte
    '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'hffffffff, 3'd7, 1'b1, 1'b0, 32'h0},         // count above four
    '{32'h12345678, 3'd1, 1'b0, 1'b0, 32'h0},         // short word not last
    '{32'hdeadbeef, 3'd5, 1'b0, 1'b0, 32'h0},
    '{32'h00000000, 3'd2, 1'b1, 1'b0, 32'h0},
    '{32'habcdef01, 3'd1, 1'b1, 1'b0, 32'h0}
  };

  function automatic logic [2:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 3'd4;
    return 3'($urandom_range(7));
  endfunction

  // random message; len words total, with occasional junk counts
  task automatic send_message(int len, bit gaps);
    for (int i = 0; i < len - 1; i++)
      send_item($urandom, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4,
                1'b0, gaps);
    send_item($urandom, rand_count(), 1'b1, gaps);
  endtask

  // main sequence
  initial begin
    int wait_cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    msg_word = '0;
    valid_bytes = '0;
    last_word = 1'b0;
    errors = 0;
    mismatches = 0;
    cycle_count = 0;
    accepted_cnt = 0;
    quiet_out = 1'b0;
    hold_out = 1'b0;
    sha_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        h0_override.push_back(dir_rows[i].exp_h0);
        h0_pos.push_back(i);
      end
      send_item(dir_rows[i].word, dir_rows[i].nbytes, dir_rows[i].last, 1'b1);
    end
    // 16 word messages force the extra padding block, 14 word ones when the last word is full
    send_message(14, 1'b1);
    send_message(16, 1'b1);

    // receiver holds off while more messages wait at the input
    hold_out = 1'b1;
    fork
      begin
        send_message(1, 1'b0);
        send_message(2, 1'b0);
        send_message(1, 1'b0);
        stop_input();
      end
      begin
        for (int c = 0; c < 3000; c++) @(posedge clk);
        hold_out = 1'b0;
      end
    join

    // random messages, with a stretch of no idling in the middle
    while (accepted_cnt < 100) begin
      quiet_out = (accepted_cnt > 55 && accepted_cnt < 85);
      send_message($urandom_range(1, 20), !quiet_out);
    end
    stop_input();
    quiet_out = 1'b0;

    while (digest_fifo.size() != 0) @(posedge clk);
    for (wait_cnt = 0; wait_cnt < 500; wait_cnt++) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
